// File: rtl/ipsm_pkg.sv
package ipsm_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned ByteW = 8;

	// Prefix length codes, tested in this order on the first byte of a number.
	localparam logic [3:0] NIB_FOUR_MORE  = 4'hF;
	localparam logic [3:0] NIB_THREE_MORE = 4'h7;
	localparam logic [2:0] LOW3_TWO_MORE  = 3'h3;
	localparam logic [1:0] LOW2_ONE_MORE  = 2'h1;

	// Length class: number of bytes after the first.
	localparam logic [2:0] LC_ZERO  = 3'd0;
	localparam logic [2:0] LC_ONE   = 3'd1;
	localparam logic [2:0] LC_TWO   = 3'd2;
	localparam logic [2:0] LC_THREE = 3'd3;
	localparam logic [2:0] LC_FOUR  = 3'd4;

	typedef enum logic [1:0] {
		PH_COUNT = 2'd0,
		PH_DELTA = 2'd1,
		PH_STATE = 2'd2
	} phase_t;

	typedef struct packed {
		logic [WordW-1:0]        entry_offset;
		logic signed [WordW-1:0] entry_state;
		logic                    last_entry;
		logic                    empty_map;
	} entry_t;

	// Bit position of the first trailing byte for each length class.
	function automatic logic [4:0] shift_base(input logic [2:0] lc);
		logic [4:0] b;
		case (lc)
			LC_FOUR:  b = 5'd0;
			LC_THREE: b = 5'd4;
			LC_TWO:   b = 5'd5;
			default:  b = 5'd6;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/ipsm_byte_if.sv
interface ipsm_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// File: rtl/ipsm_entry_if.sv
interface ipsm_entry_if;
	logic               valid;
	logic               ready;
	logic [31:0]        entry_offset;
	logic signed [31:0] entry_state;
	logic               last_entry;
	logic               empty_map;

	modport source (output valid, output entry_offset, output entry_state,
		output last_entry, output empty_map, input ready);
	modport sink (input valid, input entry_offset, input entry_state,
		input last_entry, input empty_map, output ready);
endinterface

// File: rtl/ip_to_state_map_varint_decoder.sv
// Decoder for a byte stream of packed maps from code offset to state.
//
// Channels: bytes (sink) takes one raw stream byte per request; entries
// (source) gives one decoded map entry per request: absolute offset, state
// minus one, a last-entry flag and an empty-map flag. The base_offset
// register is written via cfg_wr_en/cfg_wr_data; the user must write it only
// while idle (not enforced here); sampled when a map's entry count completes.
//
// A byte accepted into the input register passes the number decoder and
// map sequencer, and its result (if any) is loaded into the output
// register, which drives entries.valid. Throughput is one byte per cycle
// while no new result is held back by a full, stalled output register; the
// rate is set by the single combinational pass from input register to
// output register (prefix decode, one barrel shift, one 32-bit add).
//
// Reset clears the decoder and sequencer state, the register and both
// pipeline valids; the block expects an entry count right after reset.
// When the receiver stalls, the result waits in the output register; bytes
// that complete no result still advance, and bytes stall only when a new
// result would need an output register that is still full.
module ip_to_state_map_varint_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [31:0]          cfg_wr_data,
	ipsm_byte_if.sink            bytes,
	ipsm_entry_if.source         entries
);

	logic                          vld_s1;
	logic [ipsm_pkg::ByteW-1:0]    byte_s1;
	logic [ipsm_pkg::WordW-1:0]    base_offset_q;
	logic                          out_vld_s2;
	ipsm_pkg::entry_t              out_s2;

	logic                          num_done;
	logic [ipsm_pkg::WordW-1:0]    num_value;
	logic                          res_valid;
	ipsm_pkg::entry_t              res;
	ipsm_pkg::phase_t              phase;
	logic                          advance;
	logic                          load_out;

	// advance the held byte unless it makes a result and the output is full
	assign advance  = vld_s1 && (!res_valid || !out_vld_s2 || entries.ready);
	assign load_out = advance && res_valid;
	assign bytes.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_offset_q <= '0;
		end else if (cfg_wr_en) begin
			base_offset_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (bytes.ready) begin
			vld_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.in_byte;
		end
	end

	ipsm_varint u_varint (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (advance),
		.byte_in   (byte_s1),
		.num_done  (num_done),
		.num_value (num_value)
	);

	ipsm_map_seq u_map_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (advance),
		.num_done    (num_done),
		.num_value   (num_value),
		.base_offset (base_offset_q),
		.res_valid   (res_valid),
		.res         (res),
		.phase       (phase)
	);

	// output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s2 <= 1'b0;
		end else if (load_out) begin
			out_vld_s2 <= 1'b1;
		end else if (entries.ready) begin
			out_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_s2 <= res;
		end
	end

	assign entries.valid        = out_vld_s2;
	assign entries.entry_offset = out_s2.entry_offset;
	assign entries.entry_state  = out_s2.entry_state;
	assign entries.last_entry   = out_s2.last_entry;
	assign entries.empty_map    = out_s2.empty_map;

	// an empty map result carries no entry
	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		entries.valid && entries.empty_map |->
			entries.last_entry && entries.entry_offset == '0 && entries.entry_state == -32'sd1)
		else $error("empty map result malformed");

	// bytes stall only behind a full, stalled output register
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!bytes.ready |-> out_vld_s2 && !entries.ready)
		else $error("input stalled without output back-pressure");

	// a result that ends a map returns the sequencer to expecting a count
	a_last_to_count: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && res.last_entry |=> phase == ipsm_pkg::PH_COUNT)
		else $error("sequencer not back at count after last entry");

	// a result is never dropped: a full stalled output register is not overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_s2 && !entries.ready |-> !load_out)
		else $error("pending result overwritten");

endmodule

// File: rtl/ipsm_varint.sv
module ipsm_varint (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic [ipsm_pkg::ByteW-1:0] byte_in,
	output logic                       num_done,
	output logic [ipsm_pkg::WordW-1:0] num_value
);

	logic [2:0]                 bytes_left_q;
	logic [2:0]                 length_class_q;
	logic [ipsm_pkg::WordW-1:0] acc_q;

	logic [2:0]                 bytes_left_d;
	logic [2:0]                 length_class_d;
	logic [ipsm_pkg::WordW-1:0] acc_d;
	logic [2:0]                 k;
	logic [4:0]                 sh;

	always_comb begin
		k              = length_class_q - bytes_left_q;
		sh             = ipsm_pkg::shift_base(length_class_q) + {k[1:0], 3'b000};
		length_class_d = length_class_q;
		acc_d          = acc_q;
		bytes_left_d   = bytes_left_q;
		if (bytes_left_q == 3'd0) begin
			if (byte_in[3:0] == ipsm_pkg::NIB_FOUR_MORE) begin
				length_class_d = ipsm_pkg::LC_FOUR;
				acc_d          = '0;
			end else if (byte_in[3:0] == ipsm_pkg::NIB_THREE_MORE) begin
				length_class_d = ipsm_pkg::LC_THREE;
				acc_d          = ipsm_pkg::WordW'(byte_in[7:4]);
			end else if (byte_in[2:0] == ipsm_pkg::LOW3_TWO_MORE) begin
				length_class_d = ipsm_pkg::LC_TWO;
				acc_d          = ipsm_pkg::WordW'(byte_in[7:3]);
			end else if (byte_in[1:0] == ipsm_pkg::LOW2_ONE_MORE) begin
				length_class_d = ipsm_pkg::LC_ONE;
				acc_d          = ipsm_pkg::WordW'(byte_in[7:2]);
			end else begin
				length_class_d = ipsm_pkg::LC_ZERO;
				acc_d          = ipsm_pkg::WordW'(byte_in[7:1]);
			end
			bytes_left_d = length_class_d;
		end else begin
			// merge the trailing byte at its place, little endian
			acc_d        = acc_q | (ipsm_pkg::WordW'(byte_in) << sh);
			bytes_left_d = bytes_left_q - 3'd1;
		end
	end

	assign num_done  = (bytes_left_d == 3'd0);
	assign num_value = acc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q   <= '0;
			length_class_q <= '0;
			acc_q          <= '0;
		end else if (take) begin
			bytes_left_q   <= bytes_left_d;
			length_class_q <= length_class_d;
			acc_q          <= acc_d;
		end
	end

endmodule

// File: rtl/ipsm_map_seq.sv
module ipsm_map_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic                       num_done,
	input  logic [ipsm_pkg::WordW-1:0] num_value,
	input  logic [ipsm_pkg::WordW-1:0] base_offset,
	output logic                       res_valid,
	output ipsm_pkg::entry_t           res,
	output ipsm_pkg::phase_t           phase
);

	ipsm_pkg::phase_t           phase_q, phase_d;
	logic [ipsm_pkg::WordW-1:0] entries_left_q, entries_left_d;
	logic [ipsm_pkg::WordW-1:0] prev_offset_q, prev_offset_d;
	logic [ipsm_pkg::WordW-1:0] held_offset_q, held_offset_d;
	logic                       is_last;

	assign is_last = (entries_left_q == ipsm_pkg::WordW'(1));
	assign phase   = phase_q;

	// next state
	always_comb begin
		phase_d        = phase_q;
		entries_left_d = entries_left_q;
		prev_offset_d  = prev_offset_q;
		held_offset_d  = held_offset_q;
		if (num_done) begin
			unique case (phase_q)
				ipsm_pkg::PH_DELTA: begin
					held_offset_d = prev_offset_q + num_value;
					prev_offset_d = prev_offset_q + num_value;
					phase_d       = ipsm_pkg::PH_STATE;
				end
				ipsm_pkg::PH_STATE: begin
					entries_left_d = entries_left_q - ipsm_pkg::WordW'(1);
					phase_d        = is_last ? ipsm_pkg::PH_COUNT : ipsm_pkg::PH_DELTA;
				end
				default: begin
					entries_left_d = num_value;
					if (num_value == '0) begin
						phase_d = ipsm_pkg::PH_COUNT;
					end else begin
						prev_offset_d = base_offset;
						phase_d       = ipsm_pkg::PH_DELTA;
					end
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		res_valid = 1'b0;
		res       = '{entry_offset: held_offset_q,
			entry_state: $signed(num_value - ipsm_pkg::WordW'(1)),
			last_entry: is_last, empty_map: 1'b0};
		unique case (phase_q)
			ipsm_pkg::PH_DELTA: res_valid = 1'b0;
			ipsm_pkg::PH_STATE: res_valid = num_done;
			default: begin
				res_valid = num_done && (num_value == '0);
				res       = '{entry_offset: '0, entry_state: -32'sd1,
					last_entry: 1'b1, empty_map: 1'b1};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= ipsm_pkg::PH_COUNT;
			entries_left_q <= '0;
			prev_offset_q  <= '0;
			held_offset_q  <= '0;
		end else if (take) begin
			phase_q        <= phase_d;
			entries_left_q <= entries_left_d;
			prev_offset_q  <= prev_offset_d;
			held_offset_q  <= held_offset_d;
		end
	end

endmodule

// File: test/tb_ip_to_state_map_varint_decoder.sv
module tb_ip_to_state_map_varint_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles a byte needs to reach the output register, with margin.
	localparam int DrainCycles   = 4;
	// Cycles with no request on either channel before the run is declared hung.
	localparam int WatchdogLimit = 2000;
	// Receiver hold-off used to fill the pipeline and stall the byte channel.
	localparam int LongHoldOff   = 300;
	localparam int MaxReported   = 10;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	ipsm_byte_if  byte_ch ();
	ipsm_entry_if entry_ch ();

	ip_to_state_map_varint_decoder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.bytes       (byte_ch),
		.entries     (entry_ch)
	);

	// Decoder state mirrored by the predictor.
	ipsm_pkg::phase_t map_phase;
	logic [2:0]       nb_left;
	logic [2:0]       num_class;
	logic [31:0]      num_acc;
	logic [31:0]      entries_left;
	logic [31:0]      prev_offset;
	logic [31:0]      held_offset;
	logic [31:0]      map_base;

	ipsm_pkg::entry_t expected_entries[$];
	logic [7:0]       stream_bytes[$];

	// Idle controls shared by the sender, the receiver and the test tasks.
	bit tx_idle_en;
	bit rx_idle_en;
	int rx_hold_req;
	int rx_stall_left;

	int error_count;
	int bytes_sent;
	int maps_started;
	int entries_seen;
	int empty_seen;
	int base_writes;

	// Free-running clock, 20 ns period.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor: feed one accepted byte, queue the entry it completes.
	// ------------------------------------------------------------------
	function automatic void decode_stream_byte(input logic [7:0] b);
		int               sh;
		ipsm_pkg::entry_t e;
		if (nb_left == 3'd0) begin
			// First byte of a number: the prefix picks the length class.
			if (b[3:0] == ipsm_pkg::NIB_FOUR_MORE) begin
				num_class = ipsm_pkg::LC_FOUR;
				num_acc   = '0;
			end else if (b[3:0] == ipsm_pkg::NIB_THREE_MORE) begin
				num_class = ipsm_pkg::LC_THREE;
				num_acc   = 32'(b[7:4]);
			end else if (b[2:0] == ipsm_pkg::LOW3_TWO_MORE) begin
				num_class = ipsm_pkg::LC_TWO;
				num_acc   = 32'(b[7:3]);
			end else if (b[1:0] == ipsm_pkg::LOW2_ONE_MORE) begin
				num_class = ipsm_pkg::LC_ONE;
				num_acc   = 32'(b[7:2]);
			end else begin
				num_class = ipsm_pkg::LC_ZERO;
				num_acc   = 32'(b[7:1]);
			end
			nb_left = num_class;
		end else begin
			// Trailing byte: place it above the bits the first byte carried.
			case (num_class)
				ipsm_pkg::LC_FOUR:  sh = 0;
				ipsm_pkg::LC_THREE: sh = 4;
				ipsm_pkg::LC_TWO:   sh = 5;
				default:            sh = 6;
			endcase
			sh = sh + 8 * (int'(num_class) - int'(nb_left));
			if (sh < 32)
				num_acc = num_acc | (32'(b) << sh);
			nb_left = nb_left - 3'd1;
		end
		if (nb_left != 3'd0)
			return;

		case (map_phase)
			ipsm_pkg::PH_DELTA: begin
				held_offset = prev_offset + num_acc;
				prev_offset = held_offset;
				map_phase   = ipsm_pkg::PH_STATE;
			end
			ipsm_pkg::PH_STATE: begin
				e.entry_offset = held_offset;
				e.entry_state  = num_acc - 32'd1;
				e.last_entry   = (entries_left == 32'd1);
				e.empty_map    = 1'b0;
				expected_entries.push_back(e);
				entries_left = entries_left - 32'd1;
				map_phase    = (entries_left == 32'd0) ? ipsm_pkg::PH_COUNT : ipsm_pkg::PH_DELTA;
			end
			default: begin
				// Count just completed; the base is latched here, not at the write.
				maps_started++;
				entries_left = num_acc;
				if (num_acc == 32'd0) begin
					e.entry_offset = '0;
					e.entry_state  = '1;
					e.last_entry   = 1'b1;
					e.empty_map    = 1'b1;
					expected_entries.push_back(e);
					map_phase = ipsm_pkg::PH_COUNT;
				end else begin
					prev_offset = map_base;
					map_phase   = ipsm_pkg::PH_DELTA;
				end
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stream builders
	// ------------------------------------------------------------------
	function automatic int class_bits(input logic [2:0] lc);
		case (lc)
			ipsm_pkg::LC_ZERO:  return 7;
			ipsm_pkg::LC_ONE:   return 14;
			ipsm_pkg::LC_TWO:   return 21;
			ipsm_pkg::LC_THREE: return 28;
			default:            return 32;
		endcase
	endfunction

	function automatic logic [2:0] rand_class();
		case ($urandom_range(0, 4))
			0:       return ipsm_pkg::LC_ZERO;
			1:       return ipsm_pkg::LC_ONE;
			2:       return ipsm_pkg::LC_TWO;
			3:       return ipsm_pkg::LC_THREE;
			default: return ipsm_pkg::LC_FOUR;
		endcase
	endfunction

	// Random value that fits the class, with the extremes favored.
	function automatic logic [31:0] rand_value(input logic [2:0] lc);
		logic [31:0] mask;
		mask = (class_bits(lc) == 32) ? '1 : ((32'd1 << class_bits(lc)) - 32'd1);
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return mask;
			default: return $urandom & mask;
		endcase
	endfunction

	// Append one number in the given length class to the outgoing stream.
	function automatic void encode_number(input logic [31:0] v, input logic [2:0] lc);
		case (lc)
			ipsm_pkg::LC_ZERO: begin
				stream_bytes.push_back({v[6:0], 1'b0});
			end
			ipsm_pkg::LC_ONE: begin
				stream_bytes.push_back({v[5:0], ipsm_pkg::LOW2_ONE_MORE});
				stream_bytes.push_back(v[13:6]);
			end
			ipsm_pkg::LC_TWO: begin
				stream_bytes.push_back({v[4:0], ipsm_pkg::LOW3_TWO_MORE});
				stream_bytes.push_back(v[12:5]);
				stream_bytes.push_back(v[20:13]);
			end
			ipsm_pkg::LC_THREE: begin
				stream_bytes.push_back({v[3:0], ipsm_pkg::NIB_THREE_MORE});
				stream_bytes.push_back(v[11:4]);
				stream_bytes.push_back(v[19:12]);
				stream_bytes.push_back(v[27:20]);
			end
			default: begin
				// Upper nibble of the prefix byte is dropped; randomize it.
				stream_bytes.push_back({4'($urandom), ipsm_pkg::NIB_FOUR_MORE});
				stream_bytes.push_back(v[7:0]);
				stream_bytes.push_back(v[15:8]);
				stream_bytes.push_back(v[23:16]);
				stream_bytes.push_back(v[31:24]);
			end
		endcase
	endfunction

	function automatic void encode_pair();
		logic [2:0] lc;
		lc = rand_class();
		encode_number(rand_value(lc), lc);
		lc = rand_class();
		encode_number(rand_value(lc), lc);
	endfunction

	// Well-formed map with a small count, each number in a random class.
	function automatic void encode_random_map();
		int count;
		count = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
		encode_number(32'(count), rand_class());
		repeat (count) encode_pair();
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void note_error(input string msg);
		error_count++;
		if (error_count <= MaxReported)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	// Offer one byte, hold it until taken, then optionally idle.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		byte_ch.valid   <= 1'b1;
		byte_ch.in_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		decode_stream_byte(b);
		bytes_sent++;
		gap = tx_idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_stream();
		while (stream_bytes.size() != 0)
			send_byte(stream_bytes.pop_front());
	endtask

	// Drop valid, wait for every queued entry, then let the pipe empty out.
	task automatic drain_entries();
		byte_ch.valid <= 1'b0;
		while (expected_entries.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Write base_offset; only called with the block drained.
	task automatic write_base(input logic [31:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		map_base = v;
		base_writes++;
	endtask

	// ------------------------------------------------------------------
	// Receiver side: check each request, drive ready with random stalls
	// and the long hold-off when a test asks for one.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		ipsm_pkg::entry_t got;
		ipsm_pkg::entry_t want;
		if (entry_ch.valid && entry_ch.ready) begin
			got.entry_offset = entry_ch.entry_offset;
			got.entry_state  = entry_ch.entry_state;
			got.last_entry   = entry_ch.last_entry;
			got.empty_map    = entry_ch.empty_map;
			entries_seen++;
			if (got.empty_map)
				empty_seen++;
			if (expected_entries.size() == 0) begin
				note_error($sformatf("unexpected entry offset=%h state=%h last=%b empty=%b",
					got.entry_offset, got.entry_state, got.last_entry, got.empty_map));
			end else begin
				want = expected_entries.pop_front();
				if (got.entry_offset !== want.entry_offset)
					note_error($sformatf("entry_offset expected %h got %h",
						want.entry_offset, got.entry_offset));
				if (got.entry_state !== want.entry_state)
					note_error($sformatf("entry_state expected %h got %h",
						want.entry_state, got.entry_state));
				if (got.last_entry !== want.last_entry)
					note_error($sformatf("last_entry expected %b got %b",
						want.last_entry, got.last_entry));
				if (got.empty_map !== want.empty_map)
					note_error($sformatf("empty_map expected %b got %b",
						want.empty_map, got.empty_map));
			end
		end
		if (rx_hold_req > 0) begin
			rx_stall_left = rx_hold_req;
			rx_hold_req   = 0;
		end else if (rx_stall_left == 0 && rx_idle_en) begin
			rx_stall_left = pick_gap();
		end
		if (rx_stall_left > 0) begin
			entry_ch.ready <= 1'b0;
			rx_stall_left--;
		end else begin
			entry_ch.ready <= 1'b1;
		end
	end

	// Watchdog: end the run when no request moves for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WatchdogLimit) begin
			@(posedge clk);
			if ((byte_ch.valid && byte_ch.ready) || (entry_ch.valid && entry_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] watchdog: no request for %0d cycles", $realtime, WatchdogLimit);
		$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Empty maps in short and long form, a map on the reset base, then a
	// map whose offsets wrap past 2^32 and whose states hit the extremes.
	task automatic test_directed_maps();
		encode_number(32'd0, ipsm_pkg::LC_ZERO);
		encode_number(32'd0, ipsm_pkg::LC_FOUR);
		encode_number(32'd1, ipsm_pkg::LC_ZERO);
		encode_number(32'd5, ipsm_pkg::LC_ZERO);
		encode_number(32'd0, ipsm_pkg::LC_ZERO);           // state none
		send_stream();
		drain_entries();
		write_base(32'hFFFF_FFF0);
		encode_number(32'd2, ipsm_pkg::LC_ZERO);
		encode_number(32'h0FFF_FFFF, ipsm_pkg::LC_THREE);  // offset wraps
		encode_number(32'd1, ipsm_pkg::LC_TWO);            // state zero
		encode_number(32'h001F_FFFF, ipsm_pkg::LC_TWO);
		encode_number(32'h8000_0000, ipsm_pkg::LC_FOUR);   // largest positive state
		send_stream();
		drain_entries();
	endtask

	// Random well-formed maps under one base setting and idle mix.
	task automatic test_random_maps(input logic [31:0] base, input bit tx_idle,
			input bit rx_idle, input int n_bytes);
		int stop_at;
		write_base(base);
		tx_idle_en = tx_idle;
		rx_idle_en = rx_idle;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			encode_random_map();
			send_stream();
		end
		drain_entries();
	endtask

	// A base write in the middle of a map must only act on the next map.
	task automatic test_mid_map_base_write();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		write_base(32'h1234_5678);
		encode_number(32'd3, ipsm_pkg::LC_ONE);
		encode_pair();
		send_stream();
		drain_entries();
		write_base(32'hDEAD_0000);
		encode_pair();
		encode_pair();
		encode_number(32'd1, ipsm_pkg::LC_ZERO);
		encode_pair();
		send_stream();
		drain_entries();
	endtask

	// Hold the receiver off while a long map of short entries keeps coming,
	// so the output register fills and the byte channel stalls.
	task automatic test_output_backpressure();
		tx_idle_en  = 1'b0;
		rx_idle_en  = 1'b0;
		rx_hold_req = LongHoldOff;
		encode_number(32'd40, ipsm_pkg::LC_ZERO);
		repeat (40) begin
			encode_number(32'($urandom_range(0, 127)), ipsm_pkg::LC_ZERO);
			encode_number(32'($urandom_range(0, 127)), ipsm_pkg::LC_ZERO);
		end
		send_stream();
		drain_entries();
	endtask

	// Open a map with the largest count, send some entries, then raw noise.
	// The map never ends, so this runs last.
	task automatic test_long_count_and_noise();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		encode_number(32'hFFFF_FFFF, ipsm_pkg::LC_FOUR);
		repeat (6) encode_pair();
		repeat (120) stream_bytes.push_back(8'($urandom));
		send_stream();
		drain_entries();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       <= 1'b0;
		cfg_wr_data     <= '0;
		byte_ch.valid   <= 1'b0;
		byte_ch.in_byte <= '0;
		tx_idle_en      = 1'b0;
		rx_idle_en      = 1'b0;
		rx_hold_req     = 0;
		rx_stall_left   = 0;
		error_count     = 0;
		bytes_sent      = 0;
		maps_started    = 0;
		entries_seen    = 0;
		empty_seen      = 0;
		base_writes     = 0;

		// Predictor starts from the reset state.
		map_phase    = ipsm_pkg::PH_COUNT;
		nb_left      = '0;
		num_class    = ipsm_pkg::LC_ZERO;
		num_acc      = '0;
		entries_left = '0;
		prev_offset  = '0;
		held_offset  = '0;
		map_base     = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_maps();
		test_random_maps(32'hFFFF_FFFF, 1'b0, 1'b0, 260);
		test_random_maps($urandom,      1'b1, 1'b1, 260);
		test_random_maps(32'h0000_0000, 1'b1, 1'b0, 260);
		test_random_maps(32'h8000_0000, 1'b0, 1'b1, 260);
		test_mid_map_base_write();
		test_output_backpressure();
		test_random_maps($urandom,      1'b1, 1'b1, 200);
		test_long_count_and_noise();

		$display("Run covered %0d stream bytes over %0d maps, %0d entries checked (%0d empty).",
			bytes_sent, maps_started, entries_seen, empty_seen);
		$display("Base offset written %0d times; hold-off and raw noise exercised; %0d errors.",
			base_writes, error_count);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: ip_to_state_map_varint_decoder.f
rtl/ipsm_pkg.sv
rtl/ipsm_byte_if.sv
rtl/ipsm_entry_if.sv
rtl/ipsm_varint.sv
rtl/ipsm_map_seq.sv
rtl/ip_to_state_map_varint_decoder.sv
test/tb_ip_to_state_map_varint_decoder.sv
